// File: rtl/uipi_pkg.sv
// Package for the user IO and power interlock: sizes, event and fault codes,
// transaction payload types and the controller/datapath command and status.
// No dependencies.
`default_nettype none
package uipi_pkg;

	// Pin count and number of legal pin modes.
	localparam int IO_COUNT   = 8;
	localparam int MODE_COUNT = 4;
	localparam int MODE_BITS  = $clog2(MODE_COUNT);
	localparam int PACK_W     = IO_COUNT * MODE_BITS;
	localparam int EXT_W      = (PACK_W > 16) ? PACK_W : 16;

	// Event codes carried in the mode field.
	localparam logic [2:0] EV_TICK      = 3'd0;
	localparam logic [2:0] EV_RAILS     = 3'd1;
	localparam logic [2:0] EV_PIN       = 3'd2;
	localparam logic [2:0] EV_WD_TRIP   = 3'd3;
	localparam logic [2:0] EV_CLR_FAULT = 3'd4;

	// Latched fault codes.
	localparam logic [2:0] FAULT_NONE      = 3'd0;
	localparam logic [2:0] FAULT_WATCHDOG  = 3'd1;
	localparam logic [2:0] FAULT_POWER     = 3'd2;
	localparam logic [2:0] FAULT_INTERLOCK = 3'd3;
	localparam logic [2:0] FAULT_IO_AUTH   = 3'd4;

	typedef logic [MODE_BITS-1:0] pin_mode_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       rails_request_on;
		logic [7:0] pin_index;
		logic [2:0] pin_mode;
		logic       cause_removed;
		logic       reset_request;
		logic       watchdog_ok;
		logic       power_ok;
		logic       interlock_ready;
		logic       power_authorized;
		logic       io_authorized;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic        rails_on;
		logic [15:0] driven_modes;
		logic [2:0]  fault_code;
	} result_t;

	// Controller state: whether a fault is latched.
	typedef enum logic {
		ST_NO_FAULT,
		ST_FAULTED
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       write_pin;
		logic       set_rails;
		logic       make_safe;
		logic       clear_req;
		logic       load_fault;
		logic [2:0] fault_val;
		logic       update_drive;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic any_req;
		logic any_drv;
		logic rails_req;
		logic rails_en;
		logic index_ok;
		logic mode_ok;
	} status_t;

endpackage
`default_nettype wire

// File: rtl/user_io_power_interlock_unit.sv
// Top level of the user IO and power interlock: controller plus datapath.
// Depends on uipi_pkg, uipi_ctrl and uipi_dp.
// Result: the strobe is registered and comes in the cycle after start is taken.
// Throughput: one transaction per cycle; busy is always low and every event
// completes with a single update of the state registers.
// Reset: arst_n clears all requests, drives, the rails and the fault code.
// Results are shown for one cycle only; the receiver cannot stall them.
`default_nettype none
module user_io_power_interlock_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire uipi_pkg::item_t item,
	output logic                 done,
	output uipi_pkg::result_t    result
);
	import uipi_pkg::*;

	cmd_t        cmd;
	status_t     status;
	logic        take;
	logic        accepted;
	logic        rails_on;
	logic [15:0] driven_modes;
	logic [2:0]  fault_code;

	// Every event finishes with a single update of the state registers, so a transaction is always taken.
	assign busy = 1'b0;
	assign take = start && !busy;

	uipi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.status   (status),
		.cmd      (cmd),
		.done     (done),
		.accepted (accepted)
	);

	uipi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.rails_on     (rails_on),
		.driven_modes (driven_modes),
		.fault_code   (fault_code)
	);

	// The result shows the state registers right after the event.
	always_comb begin
		result.accepted     = accepted;
		result.rails_on     = rails_on;
		result.driven_modes = driven_modes;
		result.fault_code   = fault_code;
	end

endmodule
`default_nettype wire

// File: rtl/uipi_dp.sv
// Datapath of the interlock: requested and driven pin modes, rail request
// and enable, latched fault code, and the packed result view.
// Depends on uipi_pkg.
`default_nettype none
module uipi_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire uipi_pkg::item_t item,
	input  wire uipi_pkg::cmd_t  cmd,
	output uipi_pkg::status_t    status,
	output logic                 rails_on,
	output logic [15:0]          driven_modes,
	output logic [2:0]           fault_code
);
	import uipi_pkg::*;

	pin_mode_t        requested_q [IO_COUNT];
	pin_mode_t        driven_q    [IO_COUNT];
	logic             rails_req_q;
	logic             rails_en_q;
	logic [2:0]       fault_q;
	logic [PACK_W-1:0] flat;
	logic [EXT_W-1:0]  flat_ext;

	// Pin mode registers. Safe state and request clearing act on all pins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IO_COUNT; i++) begin
				requested_q[i] <= '0;
				driven_q[i]    <= '0;
			end
		end else begin
			for (int i = 0; i < IO_COUNT; i++) begin
				if (cmd.clear_req) begin
					requested_q[i] <= '0;
				end else if (cmd.write_pin && (item.pin_index == 8'(i))) begin
					requested_q[i] <= item.pin_mode[MODE_BITS-1:0];
				end
				if (cmd.make_safe) begin
					driven_q[i] <= '0;
				end else if (cmd.update_drive) begin
					driven_q[i] <= item.io_authorized ? requested_q[i] : '0;
				end
			end
		end
	end

	// Rail request, rail enable and fault code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rails_req_q <= 1'b0;
			rails_en_q  <= 1'b0;
			fault_q     <= FAULT_NONE;
		end else begin
			if (cmd.clear_req) begin
				rails_req_q <= 1'b0;
			end else if (cmd.set_rails) begin
				rails_req_q <= item.rails_request_on;
			end
			if (cmd.make_safe) begin
				rails_en_q <= 1'b0;
			end else if (cmd.update_drive) begin
				rails_en_q <= rails_req_q && item.power_authorized;
			end
			if (cmd.load_fault) begin
				fault_q <= cmd.fault_val;
			end
		end
	end

	// Status reductions over the pins and request range checks.
	always_comb begin
		status = '0;
		for (int i = 0; i < IO_COUNT; i++) begin
			if (requested_q[i] != '0) status.any_req = 1'b1;
			if (driven_q[i] != '0)    status.any_drv = 1'b1;
		end
		status.rails_req = rails_req_q;
		status.rails_en  = rails_en_q;
		status.index_ok  = ({1'b0, item.pin_index} < 9'(IO_COUNT));
		status.mode_ok   = ({1'b0, item.pin_mode} < 4'(MODE_COUNT));
	end

	// Pack the driven modes, pin 0 lowest; pins past bit 15 are not shown.
	always_comb begin
		for (int i = 0; i < IO_COUNT; i++) begin
			flat[i*MODE_BITS +: MODE_BITS] = driven_q[i];
		end
	end

	assign flat_ext     = EXT_W'(flat);
	assign driven_modes = flat_ext[15:0];
	assign rails_on     = rails_en_q;
	assign fault_code   = fault_q;

endmodule
`default_nettype wire

// File: rtl/uipi_ctrl.sv
// Controller of the interlock: decodes each event against the fault state
// and the datapath status, issues datapath commands and strobes the result.
// Depends on uipi_pkg.
`default_nettype none
module uipi_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire uipi_pkg::item_t   item,
	input  wire uipi_pkg::status_t status,
	output uipi_pkg::cmd_t         cmd,
	output logic                   done,
	output logic                   accepted
);
	import uipi_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   accepted_q;
	logic   accept_d;
	logic   faulted;

	assign faulted = (state_q == ST_FAULTED);

	// Command decode: the tick follows a fixed fault priority.
	always_comb begin
		cmd      = '0;
		accept_d = 1'b0;
		if (take) begin
			case (item.mode)
				EV_TICK: begin
					if (item.reset_request) begin
						cmd.make_safe = 1'b1; cmd.clear_req = 1'b1;
						cmd.load_fault = 1'b1; cmd.fault_val = FAULT_NONE;
					end else if (!item.watchdog_ok) begin
						cmd.make_safe = 1'b1; cmd.clear_req = 1'b1;
						cmd.load_fault = 1'b1; cmd.fault_val = FAULT_WATCHDOG;
					end else if (!item.power_ok) begin
						cmd.make_safe = 1'b1; cmd.clear_req = 1'b1;
						cmd.load_fault = 1'b1; cmd.fault_val = FAULT_POWER;
					end else if (faulted) begin
						cmd.make_safe = 1'b1;
					end else if (!item.interlock_ready) begin
						cmd.make_safe = 1'b1;
						if (status.rails_req || status.any_req ||
						    status.rails_en || status.any_drv) begin
							cmd.clear_req = 1'b1;
							cmd.load_fault = 1'b1; cmd.fault_val = FAULT_INTERLOCK;
						end
					end else if (status.rails_req && !item.power_authorized) begin
						cmd.make_safe = 1'b1; cmd.clear_req = 1'b1;
						cmd.load_fault = 1'b1; cmd.fault_val = FAULT_POWER;
					end else if (status.any_req && !item.io_authorized) begin
						cmd.make_safe = 1'b1; cmd.clear_req = 1'b1;
						cmd.load_fault = 1'b1; cmd.fault_val = FAULT_IO_AUTH;
					end else if (status.rails_en && !item.power_authorized) begin
						cmd.make_safe = 1'b1; cmd.clear_req = 1'b1;
						cmd.load_fault = 1'b1; cmd.fault_val = FAULT_POWER;
					end else if (status.any_drv && !item.io_authorized) begin
						cmd.make_safe = 1'b1; cmd.clear_req = 1'b1;
						cmd.load_fault = 1'b1; cmd.fault_val = FAULT_IO_AUTH;
					end else begin
						cmd.update_drive = 1'b1;
					end
				end
				EV_RAILS: begin
					cmd.set_rails = !faulted;
				end
				EV_PIN: begin
					if (!faulted && status.index_ok && status.mode_ok) begin
						cmd.write_pin = 1'b1;
						accept_d      = 1'b1;
					end
				end
				EV_WD_TRIP: begin
					cmd.make_safe = 1'b1; cmd.clear_req = 1'b1;
					cmd.load_fault = 1'b1; cmd.fault_val = FAULT_WATCHDOG;
				end
				EV_CLR_FAULT: begin
					if (item.cause_removed && faulted) begin
						cmd.make_safe = 1'b1; cmd.clear_req = 1'b1;
						cmd.load_fault = 1'b1; cmd.fault_val = FAULT_NONE;
						accept_d = 1'b1;
					end
				end
				default: begin
					cmd = '0;
				end
			endcase
		end
	end

	// Next state follows the fault code being loaded.
	always_comb begin
		state_d = state_q;
		if (cmd.load_fault) begin
			state_d = (cmd.fault_val == FAULT_NONE) ? ST_NO_FAULT : ST_FAULTED;
		end
	end

	// State and result strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_NO_FAULT;
			done_q     <= 1'b0;
			accepted_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= take;
			accepted_q <= accept_d;
		end
	end

	assign done     = done_q;
	assign accepted = accepted_q;

endmodule
`default_nettype wire

// File: rtl/uipi_checker.sv
// Port-level checker for the interlock top level, attached by bind.
// Depends on uipi_pkg and user_io_power_interlock_unit.
`default_nettype none
module uipi_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire uipi_pkg::item_t   item,
	input wire logic              done,
	input wire uipi_pkg::result_t result
);
	import uipi_pkg::*;

	// Every taken transaction yields its result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("no result after a taken transaction");

	// A result strobe only ever follows a taken transaction.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without a transaction");

	// With a fault latched the outputs are in the safe state.
	a_safe_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.fault_code != FAULT_NONE)) |->
		(!result.rails_on && (result.driven_modes == 16'd0)))
		else $error("outputs not safe under a fault");

	// A watchdog trip always latches the watchdog fault and is not accepted.
	a_wd_trip: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.mode == EV_WD_TRIP)) |=>
		((result.fault_code == FAULT_WATCHDOG) && !result.accepted))
		else $error("watchdog trip not latched");

	// A pin request to a pin that does not exist is rejected.
	a_bad_pin: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.mode == EV_PIN) &&
		 ({1'b0, item.pin_index} >= 9'(IO_COUNT))) |=> !result.accepted)
		else $error("request to a missing pin accepted");

endmodule

bind user_io_power_interlock_unit uipi_checker u_uipi_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);
`default_nettype wire
